// ----- src/insert_vertex_ocs_transform_assert.svh -----
// assertion macros for the insert vertex transform
`ifndef INSERT_VERTEX_OCS_TRANSFORM_ASSERT_SVH
`define INSERT_VERTEX_OCS_TRANSFORM_ASSERT_SVH

// same-cycle implication, disabled in reset
`define IVOT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define IVOT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/ivot_pkg.sv -----
package ivot_pkg;

  localparam int COORD_BITS    = 32;
  localparam int SCALE_BITS    = 32;
  localparam int AXIS_BITS     = 18;
  localparam int EXT_BITS      = 16;
  localparam int ANGLE_BITS    = 16;
  localparam int EXT_VEC_BITS  = 3 * EXT_BITS;
  localparam int CFG_DATA_BITS = EXT_VEC_BITS;
  localparam int CFG_ADDR_BITS = 3;
  localparam int TDATA_BITS    = ((3 * COORD_BITS + 7) / 8) * 8;

  // datapath widths
  localparam int SCL_BITS = COORD_BITS + SCALE_BITS - 16;
  localparam int ROT_BITS = SCL_BITS + 1;
  localparam int XYZ_BITS = ROT_BITS + 1;
  localparam int OCS_BITS = XYZ_BITS + 2;
  localparam int SUM_BITS = OCS_BITS + 1;

  // coefficient setup
  localparam int TRIG_STEPS  = 16;
  localparam int CORDIC_BITS = 34;
  localparam logic signed [CORDIC_BITS-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [EXT_BITS-1:0] EXT_THRESH = 16'sd256;
  localparam logic signed [AXIS_BITS-1:0] AXIS_MAX = 18'sd131071;
  localparam logic signed [AXIS_BITS-1:0] AXIS_MIN = -18'sd131072;

  // register indexes
  localparam logic [CFG_ADDR_BITS-1:0] REG_SCALE_X  = 3'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_SCALE_Y  = 3'd1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_SCALE_Z  = 3'd2;
  localparam logic [CFG_ADDR_BITS-1:0] REG_ROTATION = 3'd3;
  localparam logic [CFG_ADDR_BITS-1:0] REG_EXTRUDE  = 3'd4;
  localparam logic [CFG_ADDR_BITS-1:0] REG_TRANS_X  = 3'd5;
  localparam logic [CFG_ADDR_BITS-1:0] REG_TRANS_Y  = 3'd6;
  localparam logic [CFG_ADDR_BITS-1:0] REG_TRANS_Z  = 3'd7;

  typedef enum logic [2:0] {
    CS_START,
    CS_CORDIC,
    CS_TRIG,
    CS_SUMSQ,
    CS_SQRT,
    CS_DIV,
    CS_CROSS,
    CS_DONE
  } coef_state_t;

  typedef struct packed {
    logic signed [SCALE_BITS-1:0] scale_x;
    logic signed [SCALE_BITS-1:0] scale_y;
    logic signed [SCALE_BITS-1:0] scale_z;
    logic [ANGLE_BITS-1:0]        rotation_angle;
    logic [EXT_VEC_BITS-1:0]      extrusion_vector;
    logic signed [COORD_BITS-1:0] translation_x;
    logic signed [COORD_BITS-1:0] translation_y;
    logic signed [COORD_BITS-1:0] translation_z;
  } cfg_t;

  typedef struct packed {
    logic signed [AXIS_BITS-1:0] cosv;
    logic signed [AXIS_BITS-1:0] sinv;
    logic [2:0][AXIS_BITS-1:0]   ax;
    logic [2:0][AXIS_BITS-1:0]   ay;
  } coef_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [29:0] atan_lut(input logic [4:0] i);
    logic [29:0] r;
    case (i)
      5'd0:  r = 30'h20000000;
      5'd1:  r = 30'h12E4051E;
      5'd2:  r = 30'h09FB385B;
      5'd3:  r = 30'h051111D4;
      5'd4:  r = 30'h028B0D43;
      5'd5:  r = 30'h0145D7E1;
      5'd6:  r = 30'h00A2F61E;
      5'd7:  r = 30'h00517C55;
      5'd8:  r = 30'h0028BE53;
      5'd9:  r = 30'h00145F2F;
      5'd10: r = 30'h000A2F98;
      5'd11: r = 30'h000517CC;
      5'd12: r = 30'h00028BE6;
      5'd13: r = 30'h000145F3;
      5'd14: r = 30'h0000A2FA;
      5'd15: r = 30'h0000517D;
      5'd16: r = 30'h000028BE;
      5'd17: r = 30'h0000145F;
      5'd18: r = 30'h00000A30;
      5'd19: r = 30'h00000518;
      5'd20: r = 30'h0000028C;
      5'd21: r = 30'h00000146;
      5'd22: r = 30'h000000A3;
      5'd23: r = 30'h00000051;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [AXIS_BITS-1:0] sat_axis(input logic signed [47:0] v);
    logic signed [AXIS_BITS-1:0] r;
    if (v > 48'(AXIS_MAX)) begin
      r = AXIS_MAX;
    end else if (v < 48'(AXIS_MIN)) begin
      r = AXIS_MIN;
    end else begin
      r = v[AXIS_BITS-1:0];
    end
    return r;
  endfunction

endpackage

// ----- src/ivot_coef.sv -----
module ivot_coef (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               restart,
  input  logic [ivot_pkg::ANGLE_BITS-1:0]    angle,
  input  logic [ivot_pkg::EXT_VEC_BITS-1:0]  extrusion,
  output ivot_pkg::coef_t                    coef,
  output logic                               ready
);

  localparam int AB = ivot_pkg::AXIS_BITS;
  localparam int CB = ivot_pkg::CORDIC_BITS;
  localparam int VB = AB + 1;
  localparam int SQ_STEPS = 32;
  localparam int DIV_BITS = AB + 29;
  localparam logic [1:0] QUAD_II  = 2'd1;
  localparam logic [1:0] QUAD_III = 2'd2;
  localparam logic [1:0] QUAD_IV  = 2'd3;

  ivot_pkg::coef_state_t state, state_next;
  logic [5:0] cnt;
  logic [1:0] comp;
  logic       sel_y;

  logic signed [CB-1:0] cx, cy, cz;
  logic signed [VB-1:0] vec [3];
  logic [62:0] rad, root;
  logic [31:0] rem;
  logic [DIV_BITS-1:0] dvd, quo;
  logic neg;
  logic signed [AB-1:0] cosv, sinv;
  logic signed [AB-1:0] ax [3];
  logic signed [AB-1:0] ay [3];

  logic signed [15:0] ex, ey, ez;
  logic near_z;
  logic signed [CB-1:0] dx, dy, at;
  logic signed [CB-1:0] xq, yq;
  logic signed [AB-1:0] c0, s0;
  logic signed [47:0] c_w, s_w;
  logic signed [2*VB-1:0] p0, p1, p2;
  logic signed [39:0] ss;
  logic [5:0] sh;
  logic [62:0] sbit, trial;
  logic take;
  logic [32:0] rem_sh;
  logic dtake;
  logic [31:0] rem_nx;
  logic [DIV_BITS-1:0] quo_nx;
  logic signed [AB-1:0] qres;
  logic neg0, neg1;
  logic [AB-1:0] mag0, mag1;
  logic signed [VB-1:0] nv0, nv1;
  logic signed [15:0] m_a, m_c;
  logic signed [AB-1:0] m_b, m_d;
  logic signed [34:0] cd;
  logic signed [VB-1:0] ay_new;
  logic last_axis;

  always_comb begin
    ex = $signed(extrusion[47:32]);
    ey = $signed(extrusion[31:16]);
    ez = $signed(extrusion[15:0]);
    near_z = (ex < ivot_pkg::EXT_THRESH) && (ex > -ivot_pkg::EXT_THRESH) &&
             (ey < ivot_pkg::EXT_THRESH) && (ey > -ivot_pkg::EXT_THRESH);

    // cordic step
    dx = cy >>> cnt[4:0];
    dy = cx >>> cnt[4:0];
    at = $signed({4'b0, ivot_pkg::atan_lut(cnt[4:0])});

    // quadrant fold
    xq = cx >>> 14;
    yq = cy >>> 14;
    c0 = ivot_pkg::sat_axis(48'(xq));
    s0 = ivot_pkg::sat_axis(48'(yq));
    case (angle[15:14])
      QUAD_II: begin
        c_w = -48'(s0);
        s_w = 48'(c0);
      end
      QUAD_III: begin
        c_w = -48'(c0);
        s_w = -48'(s0);
      end
      QUAD_IV: begin
        c_w = 48'(s0);
        s_w = -48'(c0);
      end
      default: begin
        c_w = 48'(c0);
        s_w = 48'(s0);
      end
    endcase

    // sum of squares
    p0 = vec[0] * vec[0];
    p1 = vec[1] * vec[1];
    p2 = vec[2] * vec[2];
    ss = 40'(p0) + 40'(p1) + 40'(p2);

    // integer square root, two bits a step
    sh    = 6'd62 - {cnt[4:0], 1'b0};
    sbit  = 63'(1) << sh;
    trial = root + sbit;
    take  = rad >= trial;

    // restoring divide, one quotient bit a step
    rem_sh = {rem, dvd[DIV_BITS-1]};
    dtake  = rem_sh >= root[32:0];
    rem_nx = dtake ? 32'(rem_sh - root[32:0]) : rem_sh[31:0];
    quo_nx = {quo[DIV_BITS-2:0], dtake};
    if (neg) begin
      qres = (quo_nx >= DIV_BITS'(131072)) ? ivot_pkg::AXIS_MIN :
             -$signed({1'b0, quo_nx[AB-2:0]});
    end else begin
      qres = (quo_nx > DIV_BITS'(131071)) ? ivot_pkg::AXIS_MAX :
             $signed({1'b0, quo_nx[AB-2:0]});
    end

    neg0 = vec[0][VB-1];
    neg1 = vec[1][VB-1];
    nv0  = -vec[0];
    nv1  = -vec[1];
    mag0 = neg0 ? nv0[AB-1:0] : vec[0][AB-1:0];
    mag1 = neg1 ? nv1[AB-1:0] : vec[1][AB-1:0];

    // cross product, one component a cycle
    case (comp)
      2'd0: begin
        m_a = ey; m_b = ax[2]; m_c = ez; m_d = ax[1];
      end
      2'd1: begin
        m_a = ez; m_b = ax[0]; m_c = ex; m_d = ax[2];
      end
      default: begin
        m_a = ex; m_b = ax[1]; m_c = ey; m_d = ax[0];
      end
    endcase
    cd = 35'(m_a * m_b) - 35'(m_c * m_d);
    ay_new = VB'(cd >>> 16);

    last_axis = (comp == 2'd2);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ivot_pkg::CS_START:  state_next = ivot_pkg::CS_CORDIC;
      ivot_pkg::CS_CORDIC: begin
        if (cnt == 6'(ivot_pkg::TRIG_STEPS - 1)) state_next = ivot_pkg::CS_TRIG;
      end
      ivot_pkg::CS_TRIG:   state_next = ivot_pkg::CS_SUMSQ;
      ivot_pkg::CS_SUMSQ: begin
        if (ss == '0) begin
          state_next = sel_y ? ivot_pkg::CS_DONE : ivot_pkg::CS_CROSS;
        end else begin
          state_next = ivot_pkg::CS_SQRT;
        end
      end
      ivot_pkg::CS_SQRT: begin
        if (cnt == 6'(SQ_STEPS - 1)) state_next = ivot_pkg::CS_DIV;
      end
      ivot_pkg::CS_DIV: begin
        if (cnt == 6'(DIV_BITS - 1) && last_axis) begin
          state_next = sel_y ? ivot_pkg::CS_DONE : ivot_pkg::CS_CROSS;
        end
      end
      ivot_pkg::CS_CROSS: begin
        if (last_axis) state_next = ivot_pkg::CS_SUMSQ;
      end
      ivot_pkg::CS_DONE:   state_next = ivot_pkg::CS_DONE;
      default:             state_next = ivot_pkg::CS_START;
    endcase
    if (restart) state_next = ivot_pkg::CS_START;
  end

  // outputs
  always_comb begin
    ready = (state == ivot_pkg::CS_DONE);
    coef.cosv = cosv;
    coef.sinv = sinv;
    for (int i = 0; i < 3; i++) begin
      coef.ax[i] = ax[i];
      coef.ay[i] = ay[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ivot_pkg::CS_START;
      cnt   <= '0;
      comp  <= '0;
      sel_y <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ivot_pkg::CS_START: begin
          cnt   <= '0;
          comp  <= '0;
          sel_y <= 1'b0;
        end
        ivot_pkg::CS_CORDIC: begin
          cnt <= (cnt == 6'(ivot_pkg::TRIG_STEPS - 1)) ? '0 : cnt + 6'd1;
        end
        ivot_pkg::CS_SUMSQ: cnt <= '0;
        ivot_pkg::CS_SQRT: begin
          cnt  <= (cnt == 6'(SQ_STEPS - 1)) ? '0 : cnt + 6'd1;
          comp <= '0;
        end
        ivot_pkg::CS_DIV: begin
          if (cnt == 6'(DIV_BITS - 1)) begin
            cnt  <= '0;
            comp <= last_axis ? 2'd0 : comp + 2'd1;
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        ivot_pkg::CS_CROSS: begin
          comp <= last_axis ? 2'd0 : comp + 2'd1;
          if (last_axis) sel_y <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ivot_pkg::CS_START: begin
        cx <= ivot_pkg::CORDIC_GAIN;
        cy <= '0;
        cz <= $signed({4'b0, angle[13:0], 16'b0});
        if (near_z) begin
          vec[0] <= VB'(ez);
          vec[1] <= '0;
          vec[2] <= -VB'(ex);
        end else begin
          vec[0] <= -VB'(ey);
          vec[1] <= VB'(ex);
          vec[2] <= '0;
        end
      end
      ivot_pkg::CS_CORDIC: begin
        if (!cz[CB-1]) begin
          cx <= cx - dx;
          cy <= cy + dy;
          cz <= cz - at;
        end else begin
          cx <= cx + dx;
          cy <= cy - dy;
          cz <= cz + at;
        end
      end
      ivot_pkg::CS_TRIG: begin
        cosv <= ivot_pkg::sat_axis(c_w);
        sinv <= ivot_pkg::sat_axis(s_w);
      end
      ivot_pkg::CS_SUMSQ: begin
        rad  <= {1'b0, ss[35:0], 26'b0};
        root <= '0;
        if (ss == '0) begin
          for (int i = 0; i < 3; i++) begin
            if (sel_y) ay[i] <= '0;
            else ax[i] <= '0;
          end
        end
      end
      ivot_pkg::CS_SQRT: begin
        if (take) begin
          rad  <= rad - trial;
          root <= (root >> 1) + sbit;
        end else begin
          root <= root >> 1;
        end
        // first dividend ready for the divide
        rem <= '0;
        dvd <= {mag0, 29'b0};
        neg <= neg0;
      end
      ivot_pkg::CS_DIV: begin
        quo <= quo_nx;
        if (cnt == 6'(DIV_BITS - 1)) begin
          if (sel_y) ay[comp] <= qres;
          else ax[comp] <= qres;
          vec[0] <= vec[1];
          vec[1] <= vec[2];
          rem <= '0;
          dvd <= {mag1, 29'b0};
          neg <= neg1;
        end else begin
          rem <= rem_nx;
          dvd <= dvd << 1;
        end
      end
      ivot_pkg::CS_CROSS: begin
        vec[0] <= vec[1];
        vec[1] <= vec[2];
        vec[2] <= ay_new;
      end
      default: ;
    endcase
  end

endmodule

// ----- src/ivot_dp.sv -----
module ivot_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  ivot_pkg::cfg_t                       cfg,
  input  ivot_pkg::coef_t                      coef,
  input  logic                                 coef_ready,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [ivot_pkg::COORD_BITS-1:0] vertex_x,
  input  logic signed [ivot_pkg::COORD_BITS-1:0] vertex_y,
  input  logic signed [ivot_pkg::COORD_BITS-1:0] vertex_z,
  input  logic                                 last_vertex,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [ivot_pkg::COORD_BITS-1:0] world_x,
  output logic signed [ivot_pkg::COORD_BITS-1:0] world_y,
  output logic signed [ivot_pkg::COORD_BITS-1:0] world_z,
  output logic                                 last_out
);

  localparam int CW  = ivot_pkg::COORD_BITS;
  localparam int SW  = ivot_pkg::SCALE_BITS;
  localparam int AB  = ivot_pkg::AXIS_BITS;
  localparam int EB  = ivot_pkg::EXT_BITS;
  localparam int SCL = ivot_pkg::SCL_BITS;
  localparam int ROT = ivot_pkg::ROT_BITS;
  localparam int XYZ = ivot_pkg::XYZ_BITS;
  localparam int OCS = ivot_pkg::OCS_BITS;
  localparam int SUM = ivot_pkg::SUM_BITS;

  // products truncated toward zero
  function automatic logic signed [SCL-1:0] mul_scl(input logic signed [CW-1:0] a,
                                                    input logic signed [SW-1:0] b);
    logic signed [CW+SW-1:0] p, q;
    p = a * b;
    q = p >>> 16;
    if (p[CW+SW-1] && (p[15:0] != '0)) q = q + 1;
    return q[SCL-1:0];
  endfunction

  function automatic logic signed [ROT-1:0] mul_rot(input logic signed [AB-1:0] a,
                                                    input logic signed [SCL-1:0] b);
    logic signed [AB+SCL-1:0] p, q;
    p = a * b;
    q = p >>> 16;
    if (p[AB+SCL-1] && (p[15:0] != '0)) q = q + 1;
    return q[ROT-1:0];
  endfunction

  function automatic logic signed [OCS-1:0] mul_axis(input logic signed [XYZ-1:0] a,
                                                     input logic signed [AB-1:0] b);
    logic signed [XYZ+AB-1:0] p, q;
    p = a * b;
    q = p >>> 16;
    if (p[XYZ+AB-1] && (p[15:0] != '0)) q = q + 1;
    return q[OCS-1:0];
  endfunction

  function automatic logic signed [OCS-1:0] mul_ext(input logic signed [ROT-1:0] a,
                                                    input logic signed [EB-1:0] b);
    logic signed [ROT+EB-1:0] p, q;
    p = a * b;
    q = p >>> 14;
    if (p[ROT+EB-1] && (p[13:0] != '0)) q = q + 1;
    return q[OCS-1:0];
  endfunction

  logic en, fire;
  logic v1, v2, v3, v4, v5;
  logic l1, l2, l3, l4, l5;

  logic signed [SCL-1:0] s1_x, s1_y, s1_z;
  logic signed [ROT-1:0] s2_cx, s2_sy, s2_sx, s2_cy;
  logic signed [SCL-1:0] s2_z;
  logic signed [XYZ-1:0] s3_x, s3_y;
  logic signed [ROT-1:0] s3_z;
  logic signed [OCS-1:0] s4_px [3];
  logic signed [OCS-1:0] s4_py [3];
  logic signed [OCS-1:0] s4_pz [3];
  logic signed [CW-1:0]  s5_w  [3];

  logic signed [EB-1:0]  ext [3];
  logic signed [SUM-1:0] sum [3];
  logic signed [CW-1:0]  wsat [3];

  assign en       = !v5 || out_ready;
  assign in_ready = en && coef_ready;
  assign fire     = in_valid && in_ready;

  always_comb begin
    ext[0] = $signed(cfg.extrusion_vector[47:32]);
    ext[1] = $signed(cfg.extrusion_vector[31:16]);
    ext[2] = $signed(cfg.extrusion_vector[15:0]);
    for (int i = 0; i < 3; i++) begin
      sum[i] = SUM'(s4_px[i]) + SUM'(s4_py[i]) + SUM'(s4_pz[i]);
      if (sum[i][SUM-1:CW-1] == '0 || sum[i][SUM-1:CW-1] == '1) begin
        wsat[i] = sum[i][CW-1:0];
      end else if (sum[i][SUM-1]) begin
        wsat[i] = $signed({1'b1, {(CW-1){1'b0}}});
      end else begin
        wsat[i] = $signed({1'b0, {(CW-1){1'b1}}});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v1 <= fire;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // scale
      s1_x <= mul_scl(vertex_x, cfg.scale_x);
      s1_y <= mul_scl(vertex_y, cfg.scale_y);
      s1_z <= mul_scl(vertex_z, cfg.scale_z);
      l1   <= last_vertex;
      // rotate about z
      s2_cx <= mul_rot(coef.cosv, s1_x);
      s2_sy <= mul_rot(coef.sinv, s1_y);
      s2_sx <= mul_rot(coef.sinv, s1_x);
      s2_cy <= mul_rot(coef.cosv, s1_y);
      s2_z  <= s1_z;
      l2    <= l1;
      // translate
      s3_x <= XYZ'(s2_cx) - XYZ'(s2_sy) + XYZ'(cfg.translation_x);
      s3_y <= XYZ'(s2_sx) + XYZ'(s2_cy) + XYZ'(cfg.translation_y);
      s3_z <= ROT'(s2_z) + ROT'(cfg.translation_z);
      l3   <= l2;
      // object to world axes
      for (int i = 0; i < 3; i++) begin
        s4_px[i] <= mul_axis(s3_x, $signed(coef.ax[i]));
        s4_py[i] <= mul_axis(s3_y, $signed(coef.ay[i]));
        s4_pz[i] <= mul_ext(s3_z, ext[i]);
        s5_w[i]  <= wsat[i];
      end
      l4 <= l3;
      l5 <= l4;
    end
  end

  assign out_valid = v5;
  assign world_x   = s5_w[0];
  assign world_y   = s5_w[1];
  assign world_z   = s5_w[2];
  assign last_out  = l5;

endmodule

// ----- src/insert_vertex_ocs_transform.sv -----
// Block-insert vertex transform. Each input beat is one block vertex
// (x, y, z in signed Q16.16). It is scaled per axis, rotated about Z by the
// insert angle, offset by the translation register (insert point minus block
// base point) and mapped from object to world coordinates with the
// arbitrary-axis rule on the extrusion vector. Products truncate toward zero
// and the world coordinates saturate to 32 bits. The pipeline takes one
// vertex per clock; a stall on the output side holds every stage, nothing
// is lost or repeated. After reset and after every register write, sine,
// cosine and the two object axes are rebuilt by a sequencer with one cordic
// step, one square-root bit pair or one quotient bit per clock, the two
// square roots and six divides dominating; s_axis_tready stays low until
// it is done. The user must see that registers are written only while no
// vertex is in flight; the block itself does not enforce this.
module insert_vertex_ocs_transform (
  input  logic                                 clk,
  input  logic                                 rst,
  // vertex input
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [ivot_pkg::TDATA_BITS-1:0]      s_axis_tdata,  // vertex_x, vertex_y, vertex_z
  input  logic                                 s_axis_tlast,  // last_vertex
  // world output
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [ivot_pkg::TDATA_BITS-1:0]      m_axis_tdata,  // world_x, world_y, world_z
  output logic                                 m_axis_tlast,  // last_out
  // register writes
  input  logic                                 cfg_wr_en,
  input  logic [ivot_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
  input  logic [ivot_pkg::CFG_DATA_BITS-1:0]   cfg_wr_data
);

  localparam int CW = ivot_pkg::COORD_BITS;

  ivot_pkg::cfg_t  cfg;
  ivot_pkg::coef_t coef;
  logic            coef_ready;

  logic signed [CW-1:0] world_x, world_y, world_z;

  // register file, reset to unit scale, no rotation, extrusion along +z
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scale_x          <= 32'sh0001_0000;
      cfg.scale_y          <= 32'sh0001_0000;
      cfg.scale_z          <= 32'sh0001_0000;
      cfg.rotation_angle   <= '0;
      cfg.extrusion_vector <= 48'h0000_0000_4000;
      cfg.translation_x    <= '0;
      cfg.translation_y    <= '0;
      cfg.translation_z    <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        ivot_pkg::REG_SCALE_X:  cfg.scale_x <= $signed(cfg_wr_data[ivot_pkg::SCALE_BITS-1:0]);
        ivot_pkg::REG_SCALE_Y:  cfg.scale_y <= $signed(cfg_wr_data[ivot_pkg::SCALE_BITS-1:0]);
        ivot_pkg::REG_SCALE_Z:  cfg.scale_z <= $signed(cfg_wr_data[ivot_pkg::SCALE_BITS-1:0]);
        ivot_pkg::REG_ROTATION: cfg.rotation_angle <= cfg_wr_data[ivot_pkg::ANGLE_BITS-1:0];
        ivot_pkg::REG_EXTRUDE:  cfg.extrusion_vector <= cfg_wr_data;
        ivot_pkg::REG_TRANS_X:  cfg.translation_x <= $signed(cfg_wr_data[CW-1:0]);
        ivot_pkg::REG_TRANS_Y:  cfg.translation_y <= $signed(cfg_wr_data[CW-1:0]);
        ivot_pkg::REG_TRANS_Z:  cfg.translation_z <= $signed(cfg_wr_data[CW-1:0]);
        default: ;
      endcase
    end
  end

  // any write invalidates sine, cosine and axes
  ivot_coef u_coef (
    .clk       (clk),
    .rst       (rst),
    .restart   (cfg_wr_en),
    .angle     (cfg.rotation_angle),
    .extrusion (cfg.extrusion_vector),
    .coef      (coef),
    .ready     (coef_ready)
  );

  // five-stage vertex pipeline: scale, rotate, translate, axis products, sum
  ivot_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .coef        (coef),
    .coef_ready  (coef_ready),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .vertex_x    ($signed(s_axis_tdata[CW-1:0])),
    .vertex_y    ($signed(s_axis_tdata[2*CW-1:CW])),
    .vertex_z    ($signed(s_axis_tdata[3*CW-1:2*CW])),
    .last_vertex (s_axis_tlast),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .world_x     (world_x),
    .world_y     (world_y),
    .world_z     (world_z),
    .last_out    (m_axis_tlast)
  );

  // x in the low bits, zero pad to whole bytes
  assign m_axis_tdata = ivot_pkg::TDATA_BITS'({world_z, world_y, world_x});

endmodule

// ----- src/ivot_checker.sv -----
`include "insert_vertex_ocs_transform_assert.svh"

module ivot_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               s_axis_tready,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [ivot_pkg::TDATA_BITS-1:0]    m_axis_tdata,
  input logic                               m_axis_tlast,
  input logic                               cfg_wr_en
);

  // a stalled result beat stays put
  `IVOT_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "result beat changed while stalled")

  // a register write forces a coefficient rebuild before the next vertex
  `IVOT_ASSERT_NEXT(a_cfg_rebuild, clk, rst, cfg_wr_en, !s_axis_tready, "vertex taken right after a register write")

  // input is only taken when the pipeline can advance
  `IVOT_ASSERT_SAME(a_ready_adv, clk, rst, s_axis_tready, !m_axis_tvalid || m_axis_tready, "vertex taken while the output is stalled")

endmodule

bind insert_vertex_ocs_transform ivot_checker u_ivot_checker (.*);
